// ===== rtl/core/pwg_pkg.sv =====
package pwg_pkg;

    localparam int PERIOD_BITS_DEF      = 20;
    localparam int LEVEL_BITS_DEF       = 16;
    localparam int COSINE_ADDR_BITS_DEF = 10;

    localparam int WAVE_W  = 3;
    localparam int SYM_W   = 16;
    localparam int PHASE_W = 14;
    localparam int ADDR_W  = 3;

    // register indexes
    localparam logic [ADDR_W-1:0] REG_WAVEFORM = 3'd0;
    localparam logic [ADDR_W-1:0] REG_START    = 3'd1;
    localparam logic [ADDR_W-1:0] REG_END      = 3'd2;
    localparam logic [ADDR_W-1:0] REG_PERIOD   = 3'd3;
    localparam logic [ADDR_W-1:0] REG_SYMMETRY = 3'd4;
    localparam logic [ADDR_W-1:0] REG_PHASE    = 3'd5;

    // waveform codes
    localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 3'd0;
    localparam logic [WAVE_W-1:0] WAVE_SINE     = 3'd1;
    localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 3'd2;
    localparam logic [WAVE_W-1:0] WAVE_RAMP     = 3'd3;
    localparam logic [WAVE_W-1:0] WAVE_BIPOLAR  = 3'd4;

    localparam logic signed [PHASE_W-1:0] PHASE_MAX = 14'sd4500;
    localparam logic signed [PHASE_W-1:0] PHASE_MIN = -14'sd4500;
    localparam int PHASE_DEN = 3600;

    // pi in Q30 and the taylor term divisors (2n-1)*2n
    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam longint unsigned TERM_DIV [10] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
        64'd132, 64'd182, 64'd240, 64'd306, 64'd380
    };

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ===== rtl/core/pwg_mul.sv =====
module pwg_mul #(
    parameter int AW = 38,
    parameter int BW = 17
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [AW-1:0]      a,
    input  logic [BW-1:0]      b,
    output logic               done,
    output logic [AW+BW-1:0]   product
);
    localparam int PW   = AW + BW;
    localparam int CNTW = $clog2(BW + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [PW-1:0]   a_sh_reg;
    logic [BW-1:0]   b_sh_reg;
    logic [PW-1:0]   acc_reg;

    // one multiplier bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(BW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_sh_reg <= PW'(a);
            b_sh_reg <= b;
            acc_reg  <= '0;
        end else if (busy_reg) begin
            if (b_sh_reg[0]) begin
                acc_reg <= acc_reg + a_sh_reg;
            end
            a_sh_reg <= a_sh_reg << 1;
            b_sh_reg <= b_sh_reg >> 1;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== rtl/core/pwg_div.sv =====
module pwg_div import pwg_pkg::*; #(
    parameter int NW = 57,
    parameter int DW = 38,
    parameter int QW = 23
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [QW-1:0] quo,
    output logic          rem_nz
);
    localparam int CW   = imax(NW, DW + QW);
    localparam int CNTW = $clog2(QW + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [CW-1:0]   rem_reg;
    logic [CW-1:0]   den_sh_reg;
    logic [QW-1:0]   quo_reg;
    logic            fit;

    assign fit = (rem_reg >= den_sh_reg);

    // restoring division, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(QW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg    <= CW'(num);
            den_sh_reg <= CW'(den) << (QW - 1);
            quo_reg    <= '0;
        end else if (busy_reg) begin
            if (fit) begin
                rem_reg <= rem_reg - den_sh_reg;
            end
            quo_reg    <= {quo_reg[QW-2:0], fit};
            den_sh_reg <= den_sh_reg >> 1;
        end
    end

    assign done   = done_reg;
    assign quo    = quo_reg;
    assign rem_nz = (rem_reg != '0);

endmodule

// ===== rtl/core/periodic_waveform_generator_core.sv =====
// one result beat per input beat, one beat in flight at a time; the index comes from the
// split-point and phase multiplies, phase divide and reduction loops, then square is set
// directly, ramp and triangles take a multiply and a divide, sine a divide, a cosine ROM read
// and a multiply; a zero period skips all steps (multiplier BW = max(LEVEL_BITS+1,17) bits,
// quotient QW = max(LEVEL_BITS+2, PERIOD_BITS+3, COSINE_ADDR_BITS+3) bits); the next beat is
// accepted in the cycle after handover; one bit-serial multiplier and divider serve all steps
// reset: registers to their reset values, counter to zero, output empty; no clearing pass
module periodic_waveform_generator_core import pwg_pkg::*; #(
    parameter int PERIOD_BITS      = PERIOD_BITS_DEF,
    parameter int LEVEL_BITS       = LEVEL_BITS_DEF,
    parameter int COSINE_ADDR_BITS = COSINE_ADDR_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration writes
    input  logic                                                   cfg_wr_en,
    input  logic [ADDR_W-1:0]                                      cfg_addr,
    input  logic [imax(imax(PERIOD_BITS, LEVEL_BITS), SYM_W)-1:0]  cfg_wdata,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] restart
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [((LEVEL_BITS + 2 + PERIOD_BITS + 7) / 8) * 8 - 1:0] m_tdata, // level, position
    output logic        m_tlast,   // period_end
    output logic        m_tuser    // enabled
);
    localparam int LB       = LEVEL_BITS;
    localparam int PB       = PERIOD_BITS;
    localparam int CB       = COSINE_ADDR_BITS;
    localparam int LW       = LB + 2;
    localparam int PHB      = CB + 2;
    localparam int COS_SIZE = 1 << CB;
    localparam int XW       = PB + 18;
    localparam int BW       = imax(LB + 1, 17);
    localparam int PW       = XW + BW;
    localparam int NW       = PW + 2;
    localparam int QW       = imax(imax(LB + 2, PB + 3), PHB + 1);
    localparam int VW       = PB + 3;
    localparam int SW       = PB + 16;
    localparam int TW       = ((LW + PB + 7) / 8) * 8;
    localparam longint unsigned ROM_DIV = 64'd2 << CB;

    // quarter-wave cosine, Q1.15, from a truncating taylor series in Q30
    typedef logic [15:0] cos_rom_t [COS_SIZE];

    function automatic cos_rom_t build_cos();
        cos_rom_t          rom;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   t;
        longint unsigned   e;
        longint            sum;
        for (int k = 0; k < COS_SIZE; k++) begin
            x   = (longint'(k) * PI_Q30) / ROM_DIV;
            x2  = (x * x) >> 30;
            t   = 64'd1 << 30;
            sum = 64'sd1 << 30;
            for (int n = 1; n <= 10; n++) begin
                t = ((t * x2) >> 30) / TERM_DIV[n-1];
                if (n % 2 == 1) begin
                    sum = sum - longint'(t);
                end else begin
                    sum = sum + longint'(t);
                end
            end
            if (sum <= 0) begin
                rom[k] = 16'd0;
            end else begin
                e = (longint'(sum) + 64'd16384) >> 15;
                rom[k] = (e > 64'd32768) ? 16'h8000 : e[15:0];
            end
        end
        return rom;
    endfunction

    localparam cos_rom_t COS_ROM = build_cos();

    // sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_D_MUL  = 4'd1;
    localparam logic [3:0] ST_PH_MUL = 4'd2;
    localparam logic [3:0] ST_PH_DIV = 4'd3;
    localparam logic [3:0] ST_RED_M  = 4'd4;
    localparam logic [3:0] ST_RED_V  = 4'd5;
    localparam logic [3:0] ST_PREP   = 4'd6;
    localparam logic [3:0] ST_L_MUL  = 4'd7;
    localparam logic [3:0] ST_L_DIV  = 4'd8;
    localparam logic [3:0] ST_S_DIV  = 4'd9;
    localparam logic [3:0] ST_C_RD   = 4'd10;
    localparam logic [3:0] ST_C_WT   = 4'd11;
    localparam logic [3:0] ST_C_MUL  = 4'd12;
    localparam logic [3:0] ST_DONE   = 4'd13;

    // configuration registers
    logic [WAVE_W-1:0]  waveform_reg;
    logic [LB-1:0]      start_reg;
    logic [LB-1:0]      end_reg;
    logic [PB-1:0]      period_reg;
    logic [SYM_W-1:0]   sym_reg;
    logic [PHASE_W-1:0] phase_reg;

    // block state
    logic [3:0]         state_reg;
    logic [PB-1:0]      pos_reg;
    logic [PB-1:0]      rot_reg;
    logic [SW-1:0]      split_reg;

    // per-beat working registers
    logic [PB-1:0]      p_reg;
    logic               last_reg;
    logic               valid_reg;
    logic [VW-1:0]      mag_reg;
    logic [VW-1:0]      v_reg;
    logic signed [LW-1:0] base_reg;
    logic               sgn_reg;
    logic               fix_reg;
    logic [XW-1:0]      y_reg;
    logic signed [LW-1:0] level_reg;
    logic               sin_hi_reg;
    logic [PHB-1:0]     pp_reg;
    logic [15:0]        cos_q_reg;

    // output stage
    logic               out_valid_reg;
    logic signed [LW-1:0] out_level_reg;
    logic [PB-1:0]      out_pos_reg;
    logic               out_last_reg;
    logic               out_en_reg;

    // shared serial units
    logic               mul_go_reg;
    logic [XW-1:0]      mul_a_reg;
    logic [BW-1:0]      mul_b_reg;
    logic               mul_done;
    logic [PW-1:0]      mul_p;
    logic               div_go_reg;
    logic [NW-1:0]      div_num_reg;
    logic [XW-1:0]      div_den_reg;
    logic               div_done;
    logic [QW-1:0]      div_q;
    logic               div_rnz;

    pwg_mul #(.AW(XW), .BW(BW)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_go_reg),
        .a       (mul_a_reg),
        .b       (mul_b_reg),
        .done    (mul_done),
        .product (mul_p)
    );

    pwg_div #(.NW(NW), .DW(XW), .QW(QW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_go_reg),
        .num     (div_num_reg),
        .den     (div_den_reg),
        .done    (div_done),
        .quo     (div_q),
        .rem_nz  (div_rnz)
    );

    // levels and their difference
    logic signed [LB:0]  r_s;
    logic                sgr;
    logic [LB:0]         ar;
    logic signed [LW-1:0] s_x;
    logic signed [LW-1:0] e_x;

    assign r_s = $signed({end_reg[LB-1], end_reg}) - $signed({start_reg[LB-1], start_reg});
    assign sgr = r_s[LB];
    assign ar  = sgr ? (LB+1)'(-r_s) : (LB+1)'(r_s);
    assign s_x = LW'($signed(start_reg));
    assign e_x = LW'($signed(end_reg));

    // phase magnitude and validity
    logic [PHASE_W-1:0] aph;
    logic               cfg_valid;

    assign aph       = phase_reg[PHASE_W-1] ? PHASE_W'(-$signed(phase_reg)) : phase_reg;
    assign cfg_valid = (waveform_reg <= WAVE_BIPOLAR) &&
                       ($signed(phase_reg) >= PHASE_MIN) && ($signed(phase_reg) <= PHASE_MAX);

    // sample position for an accepted beat
    logic [PB-1:0] p_new;
    logic          last_new;

    assign p_new    = (s_tdata[0] || pos_reg >= period_reg) ? '0 : pos_reg;
    assign last_new = (p_new == period_reg - 1'b1);

    // index, split point and full period in units of 1/65536 sample
    logic [XW-1:0] i_x;
    logic [XW-1:0] i2_x;
    logic [XW-1:0] d_x;
    logic [XW-1:0] nd_x;
    logic [XW-1:0] nd2_x;
    logic          first_half;

    assign i_x        = XW'({rot_reg, 16'b0});
    assign i2_x       = i_x << 1;
    assign d_x        = XW'(split_reg);
    assign nd_x       = XW'({period_reg, 16'b0});
    assign nd2_x      = nd_x << 1;
    assign first_half = (i_x < d_x);

    // operands of the linear segment: level = base + round(+-|r|*x / y)
    logic signed [LW-1:0] prep_base;
    logic                 prep_sgn;
    logic [XW-1:0]        prep_x;
    logic [XW-1:0]        prep_y;

    always_comb begin
        prep_base = s_x;
        prep_sgn  = sgr;
        prep_x    = '0;
        prep_y    = '0;
        case (waveform_reg)
            WAVE_RAMP: begin
                prep_x = XW'(rot_reg);
                prep_y = XW'(period_reg);
            end
            WAVE_TRIANGLE: begin
                if (first_half) begin
                    prep_x = i_x;
                    prep_y = d_x;
                end else begin
                    prep_base = e_x;
                    prep_sgn  = !sgr;
                    prep_x    = i_x - d_x;
                    prep_y    = nd_x - d_x;
                end
            end
            WAVE_BIPOLAR: begin
                if (i2_x < d_x) begin
                    prep_x = i2_x;
                    prep_y = d_x;
                end else if (i2_x < nd2_x - d_x) begin
                    prep_base = e_x;
                    prep_sgn  = !sgr;
                    prep_x    = i2_x - d_x;
                    prep_y    = nd_x - d_x;
                end else begin
                    // tail below the start level
                    prep_sgn = !sgr;
                    prep_x   = nd2_x - i2_x;
                    prep_y   = d_x;
                end
            end
            default: begin
            end
        endcase
    end

    // sine phase division operands
    logic [NW-1:0] sin_num;
    logic [XW-1:0] sin_den;

    assign sin_num = first_half ?
        ((NW'(i_x) << (PHB + 1)) + (NW'(d_x) << 1)) :
        ((NW'(i_x - d_x) << (PHB + 1)) + (NW'(nd_x - d_x) << 1));
    assign sin_den = first_half ? (d_x << 2) : ((nd_x - d_x) << 2);

    // rounding step of the linear segment
    logic [NW-1:0] m2;
    logic [NW-1:0] y_n;
    logic          m_over;

    assign m2     = NW'(mul_p) << 1;
    assign y_n    = NW'(y_reg);
    assign m_over = (m2 > y_n);

    logic signed [LW-1:0] q_mag;
    logic signed [LW-1:0] q_s;

    assign q_mag = $signed(LW'(div_q));
    assign q_s   = fix_reg ? -(q_mag + LW'(div_rnz)) : q_mag;

    // cosine by quadrant symmetry
    logic [1:0]           quad;
    logic [CB-1:0]        off;
    logic [CB-1:0]        rom_addr;
    logic                 quarter_zero;
    logic signed [17:0]   c_s;
    logic signed [17:0]   w_s;

    assign quad         = pp_reg[PHB-1:PHB-2];
    assign off          = pp_reg[CB-1:0];
    assign rom_addr     = quad[0] ? CB'(-off) : off;
    assign quarter_zero = quad[0] && (off == '0);
    assign c_s          = quarter_zero ? 18'sd0 :
                          ((quad[1] ^ quad[0]) ? -$signed({2'b00, cos_q_reg}) :
                                                  $signed({2'b00, cos_q_reg}));
    assign w_s          = 18'sd32768 - c_s;

    always_ff @(posedge aclk) begin
        cos_q_reg <= COS_ROM[rom_addr];
    end

    // sine level: s + floor((+-|r|*w + 32768) / 65536)
    logic signed [PW+1:0] cm_s;
    logic signed [PW+1:0] ct_s;

    assign cm_s = sgr ? -$signed({2'b00, mul_p}) : $signed({2'b00, mul_p});
    assign ct_s = (cm_s + (PW+2)'(32768)) >>> 16;

    // index reduction
    logic [VW-1:0] n_v;
    assign n_v = VW'(period_reg);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            waveform_reg <= WAVE_SQUARE;
            start_reg    <= {1'b1, {(LB-1){1'b0}}};
            end_reg      <= {1'b0, {(LB-1){1'b1}}};
            period_reg   <= '0;
            sym_reg      <= '0;
            phase_reg    <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_WAVEFORM: waveform_reg <= cfg_wdata[WAVE_W-1:0];
                REG_START:    start_reg    <= cfg_wdata[LB-1:0];
                REG_END:      end_reg      <= cfg_wdata[LB-1:0];
                REG_PERIOD:   period_reg   <= cfg_wdata[PB-1:0];
                REG_SYMMETRY: sym_reg      <= cfg_wdata[SYM_W-1:0];
                REG_PHASE:    phase_reg    <= cfg_wdata[PHASE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            rot_reg       <= '0;
            split_reg     <= '0;
            out_valid_reg <= 1'b0;
            mul_go_reg    <= 1'b0;
            div_go_reg    <= 1'b0;
        end else begin
            mul_go_reg <= 1'b0;
            div_go_reg <= 1'b0;
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        level_reg <= '0;
                        if (period_reg == '0) begin
                            // disabled: all-zero beat, counter held at zero
                            pos_reg   <= '0;
                            rot_reg   <= '0;
                            split_reg <= '0;
                            p_reg     <= '0;
                            last_reg  <= 1'b0;
                            valid_reg <= 1'b0;
                            state_reg <= ST_DONE;
                        end else begin
                            p_reg      <= p_new;
                            last_reg   <= last_new;
                            pos_reg    <= last_new ? '0 : p_new + 1'b1;
                            valid_reg  <= cfg_valid;
                            // split point: N * (32768 + symmetry)
                            mul_a_reg  <= XW'(period_reg);
                            mul_b_reg  <= BW'({~sym_reg[SYM_W-1], sym_reg[SYM_W-2:0]});
                            mul_go_reg <= 1'b1;
                            state_reg  <= ST_D_MUL;
                        end
                    end
                end
                ST_D_MUL: begin
                    if (mul_done) begin
                        split_reg  <= mul_p[SW-1:0];
                        mul_a_reg  <= XW'(period_reg);
                        mul_b_reg  <= BW'(aph);
                        mul_go_reg <= 1'b1;
                        state_reg  <= ST_PH_MUL;
                    end
                end
                ST_PH_MUL: begin
                    if (mul_done) begin
                        div_num_reg <= NW'(mul_p);
                        div_den_reg <= XW'(PHASE_DEN);
                        div_go_reg  <= 1'b1;
                        state_reg   <= ST_PH_DIV;
                    end
                end
                ST_PH_DIV: begin
                    if (div_done) begin
                        mag_reg   <= div_q[VW-1:0];
                        state_reg <= ST_RED_M;
                    end
                end
                ST_RED_M: begin
                    // shift magnitude mod N, then index before its final wrap
                    if (mag_reg >= n_v) begin
                        mag_reg <= mag_reg - n_v;
                    end else begin
                        v_reg     <= phase_reg[PHASE_W-1] ?
                                     VW'(p_reg) + n_v + mag_reg :
                                     VW'(p_reg) + n_v - mag_reg;
                        state_reg <= ST_RED_V;
                    end
                end
                ST_RED_V: begin
                    if (v_reg >= n_v) begin
                        v_reg <= v_reg - n_v;
                    end else begin
                        rot_reg   <= v_reg[PB-1:0];
                        state_reg <= valid_reg ? ST_PREP : ST_DONE;
                    end
                end
                ST_PREP: begin
                    case (waveform_reg)
                        WAVE_SQUARE: begin
                            level_reg <= first_half ? s_x : e_x;
                            state_reg <= ST_DONE;
                        end
                        WAVE_SINE: begin
                            sin_hi_reg  <= !first_half;
                            div_num_reg <= sin_num;
                            div_den_reg <= sin_den;
                            div_go_reg  <= 1'b1;
                            state_reg   <= ST_S_DIV;
                        end
                        WAVE_RAMP, WAVE_TRIANGLE, WAVE_BIPOLAR: begin
                            base_reg   <= prep_base;
                            sgn_reg    <= prep_sgn;
                            y_reg      <= prep_y;
                            mul_a_reg  <= prep_x;
                            mul_b_reg  <= BW'(ar);
                            mul_go_reg <= 1'b1;
                            state_reg  <= ST_L_MUL;
                        end
                        default: begin
                            state_reg <= ST_DONE;
                        end
                    endcase
                end
                ST_L_MUL: begin
                    if (mul_done) begin
                        // floor((2*num + y) / (2*y)) on magnitudes
                        fix_reg <= sgn_reg && m_over;
                        if (sgn_reg) begin
                            div_num_reg <= m_over ? m2 - y_n : '0;
                        end else begin
                            div_num_reg <= m2 + y_n;
                        end
                        div_den_reg <= y_reg << 1;
                        div_go_reg  <= 1'b1;
                        state_reg   <= ST_L_DIV;
                    end
                end
                ST_L_DIV: begin
                    if (div_done) begin
                        level_reg <= base_reg + q_s;
                        state_reg <= ST_DONE;
                    end
                end
                ST_S_DIV: begin
                    if (div_done) begin
                        pp_reg    <= div_q[PHB-1:0] + (PHB'(sin_hi_reg) << (PHB - 1));
                        state_reg <= ST_C_RD;
                    end
                end
                ST_C_RD: begin
                    state_reg <= ST_C_WT;
                end
                ST_C_WT: begin
                    mul_a_reg  <= XW'(w_s[16:0]);
                    mul_b_reg  <= BW'(ar);
                    mul_go_reg <= 1'b1;
                    state_reg  <= ST_C_MUL;
                end
                ST_C_MUL: begin
                    if (mul_done) begin
                        level_reg <= s_x + LW'(ct_s);
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // hand over once the output stage is free or draining
                    if (!out_valid_reg || m_tready) begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && (!out_valid_reg || m_tready)) begin
            out_level_reg <= valid_reg ? level_reg : '0;
            out_pos_reg   <= p_reg;
            out_last_reg  <= last_reg;
            out_en_reg    <= valid_reg;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TW'({out_pos_reg, out_level_reg});
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_en_reg;

endmodule
